/* hdl/random_looping_step_sequencer_defines.svh */
// Assertion macros shared by the sequencer's checking code.
`ifndef RANDOM_LOOPING_STEP_SEQUENCER_DEFINES_SVH
`define RANDOM_LOOPING_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RLSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RLSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rlss_pkg.sv */
// Types, constants and the loop length table of the random looping sequencer.
package rlss_pkg;

  localparam int STEP_SLOTS  = 16;
  localparam int GATE_SLOTS  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHANGE_FLOOR = 8'd15;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_LOCK   = 2'd2;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic [1:0] kind;
    logic       clock_level;
    logic       normal_mode;
    logic [7:0] change_level;
    logic [2:0] length_select;
    logic       clear_held;
    logic [7:0] decide_byte;
    logic [7:0] value_byte;
    logic [7:0] gate_byte;
    logic [7:0] prob_value;
  } item_t;

  // State of the execution side, for the checks at the top level.
  typedef struct packed {
    logic       idle;
    logic       in_mutate;
    logic       gate;
    logic [3:0] position;
    logic [4:0] active_length;
  } back_status_t;

  function automatic logic [4:0] length_for_select(input logic [2:0] sel);
    logic [4:0] len;
    unique case (sel)
      3'd0:    len = 5'd2;
      3'd1:    len = 5'd3;
      3'd2:    len = 5'd4;
      3'd3:    len = 5'd5;
      3'd4:    len = 5'd6;
      3'd5:    len = 5'd8;
      3'd6:    len = 5'd12;
      default: len = 5'd16;
    endcase
    return len;
  endfunction

endpackage

/* hdl/rlss_front.sv */
// Front end: unpacks incoming requests, drops unused codes and feeds the queue.
module rlss_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output rlss_pkg::item_t      q_item
);

  logic known;

  // Requests are taken whenever the queue has room; the unused code is
  // swallowed without reaching the back end.
  assign s_tready = !q_full;
  assign known    = (s_tuser == rlss_pkg::REQ_SAMPLE) || (s_tuser == rlss_pkg::REQ_WRITE) ||
                    (s_tuser == rlss_pkg::REQ_LOCK);
  assign q_push   = s_tvalid && s_tready && known;

  always_comb begin
    q_item.kind          = s_tuser;
    q_item.clock_level   = s_tdata[0];
    q_item.normal_mode   = s_tdata[1];
    q_item.change_level  = s_tdata[9:2];
    q_item.length_select = s_tdata[12:10];
    q_item.clear_held    = s_tdata[13];
    q_item.decide_byte   = s_tdata[28:21];
    q_item.value_byte    = s_tdata[37:30];
    q_item.gate_byte     = s_tdata[61:54];
    q_item.prob_value    = s_tdata[69:62];
  end

endmodule

/* hdl/rlss_fifo.sv */
// Short request queue between the front and the back end.
module rlss_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlss_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output rlss_pkg::item_t head
);

  localparam int PTR_W = $clog2(rlss_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rlss_pkg::QUEUE_DEPTH + 1);

  rlss_pkg::item_t  entries [rlss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(rlss_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/rlss_back.sv */
// Back end: sequencer state, step advance with a subtractive modulo, mutation and result register.
module rlss_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   random_mode,
  input  logic                   q_nonempty,
  input  rlss_pkg::item_t        q_head,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,
  output rlss_pkg::back_status_t status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MOD    = 2'd1;
  localparam logic [1:0] S_MUTATE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam int POS_W  = $clog2(rlss_pkg::STEP_SLOTS);
  localparam int SLOT_W = $clog2(rlss_pkg::GATE_SLOTS);

  logic [1:0]       state;
  rlss_pkg::item_t  cur;
  logic [7:0]       step_values [rlss_pkg::STEP_SLOTS];
  logic [7:0]       gate_chances [rlss_pkg::GATE_SLOTS];
  logic [15:0]      shift_bits;
  logic [POS_W-1:0] position;
  logic [4:0]       active_length;
  logic [7:0]       active_change;
  logic             editing_on;
  logic             previous_clock;
  logic             gate_out;
  logic [7:0]       held_bits;
  logic             rose;
  logic [4:0]       remainder;

  logic             rising;
  logic             falling;
  logic [4:0]       sel_length;
  logic             apply;
  logic [3:0]       tap;
  logic             fed_bit;
  logic [7:0]       step_byte;
  logic [7:0]       chance;
  logic             out_free;

  assign rising     = !previous_clock && q_head.clock_level;
  assign falling    = previous_clock && !q_head.clock_level;
  assign sel_length = rlss_pkg::length_for_select(q_head.length_select);
  assign q_pop      = (state == S_IDLE) && q_nonempty;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    apply = (active_change > rlss_pkg::CHANGE_FLOOR) && (cur.decide_byte < active_change);
    tap   = 4'((5'd16 - active_length));
    fed_bit = shift_bits[tap] ^ apply;
    if (cur.clear_held) begin
      fed_bit = 1'b0;
    end
    if (cur.clear_held) begin
      step_byte = 8'd0;
    end else if (apply) begin
      step_byte = cur.value_byte;
    end else begin
      step_byte = step_values[position];
    end
    chance = gate_chances[position[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      shift_bits     <= '0;
      position       <= '0;
      active_length  <= 5'd2;
      active_change  <= '0;
      editing_on     <= 1'b1;
      previous_clock <= 1'b0;
      gate_out       <= 1'b0;
      held_bits      <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < rlss_pkg::STEP_SLOTS; i++) begin
        step_values[i] <= '0;
      end
      for (int i = 0; i < rlss_pkg::GATE_SLOTS; i++) begin
        gate_chances[i] <= 8'hFF;
      end
    end else begin
      // A result taken while the next one is ready is replaced in S_EMIT.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_nonempty) begin
            cur <= q_head;
            case (q_head.kind)
              rlss_pkg::REQ_WRITE: begin
                gate_chances[q_head.length_select[SLOT_W-1:0]] <= q_head.prob_value;
              end
              rlss_pkg::REQ_LOCK: begin
                editing_on <= 1'b0;
              end
              rlss_pkg::REQ_SAMPLE: begin
                previous_clock <= q_head.clock_level;
                rose           <= rising;
                if (rising) begin
                  if (q_head.normal_mode) begin
                    if (editing_on) begin
                      active_change <= q_head.change_level;
                      active_length <= sel_length;
                    end else if ((q_head.change_level < rlss_pkg::CHANGE_FLOOR) &&
                                 (sel_length == active_length)) begin
                      editing_on <= 1'b1;
                    end
                  end
                  remainder <= 5'(position) + 5'd1;
                  state     <= S_MOD;
                end else begin
                  if (falling) begin
                    gate_out <= 1'b0;
                  end
                  state <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MOD: begin
          if (remainder >= active_length) begin
            remainder <= remainder - active_length;
          end else begin
            position <= remainder[POS_W-1:0];
            state    <= S_MUTATE;
          end
        end
        S_MUTATE: begin
          if (random_mode) begin
            shift_bits <= {fed_bit, shift_bits[15:1]};
            held_bits  <= shift_bits[8:1];
          end else begin
            step_values[position] <= step_byte;
            held_bits             <= step_byte;
          end
          if ((chance > rlss_pkg::CHANGE_FLOOR) && (cur.gate_byte < chance)) begin
            gate_out <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded together with m_tvalid.
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      m_tdata <= {1'b0, position, cur.normal_mode && editing_on, rose, gate_out, held_bits};
    end
  end

  always_comb begin
    status.idle          = (state == S_IDLE);
    status.in_mutate     = (state == S_MUTATE);
    status.gate          = gate_out;
    status.position      = position;
    status.active_length = active_length;
  end

endmodule

/* hdl/random_looping_step_sequencer.sv */
// Top level of the random looping step sequencer.
//
// The block takes requests on the s_ stream channel: s_tuser carries the request
// kind (clock pin sample, gate probability write, editing lock) and s_tdata the
// panel readings and random words. Every clock pin sample produces one result on
// the m_ stream channel; the other two kinds only change state, and the unused
// kind is dropped. The one-bit random_mode register is written through cfg_we
// and cfg_data; the user must write it only while the block is idle (not enforced).
//
// Requests pass through a two-entry queue into the execution side, which handles
// one request at a time. A steady or falling clock sample goes from idle to the
// emit state, and a write or lock is handled in the idle state alone. A rising edge
// also passes the modulo and mutate states: the step advance is a remainder by the
// loop length, worked out by repeated subtraction at one subtraction per cycle.
//
// Synchronous reset clears the queue and the result valid flag and restores every
// step value, gate probability and the step position to its starting value. When the
// receiver stalls, the result waits in the output register and the queue keeps
// taking requests until it is full, after which s_tready falls.
module random_looping_step_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,    // random_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: clock_level, normal_mode, change_level[7:0], length_select[2:0],
  // clear_held, rand_decide[15:0], rand_value[15:0], rand_gate[15:0], prob_value[7:0]
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,     // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: random_bits[7:0], gate_level, new_step, show_on_leds,
  // step_position[3:0]
  output logic [15:0] m_tdata
);

`include "random_looping_step_sequencer_defines.svh"

  logic                   random_mode;
  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_nonempty;
  rlss_pkg::item_t        q_item;
  rlss_pkg::item_t        q_head;
  rlss_pkg::back_status_t status;

  // The user must write the mode register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      random_mode <= 1'b0;
    end else if (cfg_we) begin
      random_mode <= cfg_data;
    end
  end

  rlss_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  rlss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  rlss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .random_mode (random_mode),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .status      (status)
  );

  // Between requests the step position always lies inside the active loop.
  `RLSS_ASSERT_NOW(a_position_in_loop, clk, rst, status.idle,
    status.position < status.active_length, "step position outside the active loop")

  // The gate only rises in the cycle after a step has been mutated.
  `RLSS_ASSERT_NOW(a_gate_rises_on_step, clk, rst, $rose(status.gate),
    $past(status.in_mutate), "gate rose outside a step")

  // A request is never taken from the queue while the back end is busy.
  `RLSS_ASSERT_NEXT(a_single_request, clk, rst, q_pop && q_head.kind == rlss_pkg::REQ_SAMPLE,
    !q_pop, "back end took a second request while busy")

endmodule
